/* design/edge_non_maxima_suppression_macros.svh */
// assertion macros shared by the checker
`ifndef EDGE_NON_MAXIMA_SUPPRESSION_MACROS_SVH
`define EDGE_NON_MAXIMA_SUPPRESSION_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ENMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("enms same-cycle check failed");

// next-cycle implication, skipped while reset is high
`define ENMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("enms next-cycle check failed");

`endif

/* design/enms_pkg.sv */
`default_nettype none

package enms_pkg;

  // fixed field widths
  localparam int MAG_BITS        = 16;
  localparam int ANGLE_BITS      = 8;
  localparam int FRAME_W_BITS    = 11;
  localparam int FRAME_H_BITS    = 13;
  localparam int ROW_BITS        = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAX_HEIGHT        = 4096;

  localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RESET   = 11'd640;
  localparam logic [FRAME_H_BITS-1:0] FRAME_HEIGHT_RESET  = 13'd480;
  localparam logic [MAG_BITS-1:0]     MIN_MAGNITUDE_RESET = 16'd50;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_MAGNITUDE = 2'd2;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [MAG_BITS-1:0]   magnitude;
    logic [ANGLE_BITS-1:0] angle;
  } pixel_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] value;
    logic                end_of_frame;
  } result_t;

  // what the position counter tells the thinning stage about one item
  typedef struct packed {
    logic ending;
    logic has_result;
    logic pass_through;
    logic border;
  } pos_flags_t;

endpackage

`default_nettype wire

/* design/enms_ram.sv */
`default_nettype none

module enms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/enms_position.sv */
`default_nettype none

module enms_position
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 advance,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
  input  wire logic [ROW_BITS-1:0]                  height_eff,
  output logic      [$clog2(MAX_WIDTH)-1:0]         col,
  output pos_flags_t                                flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [ROW_BITS-1:0] row;
  logic [ROW_BITS-1:0] centre_row;
  logic [WW-1:0]       col_wide;
  logic [WW-1:0]       col_inc;
  logic                col_zero;

  assign col_wide = WW'(col);
  assign col_inc  = col_wide + WW'(1);
  assign col_zero = (col == '0);

  // centre pixel sits one row and one column back
  assign centre_row = col_zero ? (row - ROW_BITS'(2)) : (row - ROW_BITS'(1));

  always_comb begin
    flags.ending       = (row > height_eff);
    flags.has_result   = flags.ending || (!col_zero && row != '0) ||
                         (col_zero && row >= ROW_BITS'(2));
    flags.pass_through = (centre_row == '0) || (centre_row >= height_eff - ROW_BITS'(1));
    flags.border       = col_zero || (col == CW'(1)) || (col_wide >= width_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (flags.ending) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= width_eff) begin
        col <= '0;
        row <= row + ROW_BITS'(1);
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* design/enms_thin.sv */
`default_nettype none

module enms_thin
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire pixel_t                       pixel,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
  input  wire pos_flags_t                   flags,
  input  wire logic [MAG_BITS-1:0]          min_magnitude,
  output logic                              stall,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output result_t                           result
);

  localparam int CW = $clog2(MAX_WIDTH);

  localparam logic [1:0] DIR_DIAG      = 2'd0;
  localparam logic [1:0] DIR_VERTICAL  = 2'd1;
  localparam logic [1:0] DIR_ANTI_DIAG = 2'd2;
  localparam logic [1:0] DIR_HORIZ     = 2'd3;

  // item held between the line buffer read and the result register
  logic                  s1_valid;
  logic [MAG_BITS-1:0]   s1_mag;
  logic [ANGLE_BITS-1:0] s1_ang;
  logic [CW-1:0]         s1_col;
  pos_flags_t            s1_flags;

  logic [MAG_BITS-1:0]   win [6];
  logic [ANGLE_BITS-1:0] center_angle;

  logic [MAG_BITS-1:0]   upper_rd;
  logic [MAG_BITS-1:0]   middle_rd;
  logic [ANGLE_BITS-1:0] angle_rd;

  logic                  go;
  logic                  commit;
  logic [1:0]            dir;
  logic [MAG_BITS-1:0]   centre;
  logic [MAG_BITS-1:0]   g1;
  logic [MAG_BITS-1:0]   g2;
  logic [MAG_BITS-1:0]   val;

  function automatic logic [1:0] direction(input logic [ANGLE_BITS-1:0] ang);
    logic [2:0] octant;
    octant = ang[ANGLE_BITS-2:ANGLE_BITS-4] + 3'd7;
    return octant[2:1];
  endfunction

  assign go     = !s1_valid || !s1_flags.has_result || !result_valid || !result_stall;
  assign stall  = !go;
  assign commit = s1_valid && go;

  enms_ram #(
    .WIDTH(MAG_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk    (clk),
    .wr_en  (commit),
    .wr_addr(s1_col),
    .wr_data(middle_rd),
    .rd_en  (accept),
    .rd_addr(col),
    .rd_data(upper_rd)
  );

  enms_ram #(
    .WIDTH(MAG_BITS + ANGLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_middle (
    .clk    (clk),
    .wr_en  (commit),
    .wr_addr(s1_col),
    .wr_data({s1_mag, s1_ang}),
    .rd_en  (accept),
    .rd_addr(col),
    .rd_data({middle_rd, angle_rd})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  // flush items count as zero pixels
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag   <= (pixel.command == CMD_FLUSH) ? '0 : pixel.magnitude;
      s1_ang   <= (pixel.command == CMD_FLUSH) ? '0 : pixel.angle;
      s1_col   <= col;
      s1_flags <= flags;
    end
  end

  assign centre = win[4];
  assign dir    = direction(center_angle);

  always_comb begin
    unique case (dir)
      DIR_DIAG: begin
        g1 = win[0];
        g2 = s1_mag;
      end
      DIR_VERTICAL: begin
        g1 = win[3];
        g2 = win[5];
      end
      DIR_ANTI_DIAG: begin
        g1 = upper_rd;
        g2 = win[2];
      end
      DIR_HORIZ: begin
        g1 = middle_rd;
        g2 = win[1];
      end
      default: begin
        g1 = '0;
        g2 = '0;
      end
    endcase
  end

  always_comb begin
    priority if (s1_flags.ending || s1_flags.pass_through) begin
      val = centre;
    end else if (s1_flags.border || centre < min_magnitude) begin
      val = '0;
    end else if (g1 > centre || g2 > centre) begin
      val = '0;
    end else begin
      val = centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      center_angle <= '0;
    end else if (commit) begin
      win[0]       <= win[3];
      win[1]       <= win[4];
      win[2]       <= win[5];
      win[3]       <= upper_rd;
      win[4]       <= middle_rd;
      win[5]       <= s1_mag;
      center_angle <= angle_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit && s1_flags.has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && s1_flags.has_result) begin
      result.value        <= val;
      result.end_of_frame <= s1_flags.ending;
    end
  end

endmodule

`default_nettype wire

/* design/edge_non_maxima_suppression.sv */
// edge non-maxima suppression, 3x3 window, one channel
// pixel channel: pixel_valid / pixel_stall, payload pixel (command, magnitude,
//   angle) in raster order; a transfer happens when valid is high and stall low
// result channel: result_valid / result_stall, payload result (value,
//   end_of_frame); each result is the pixel one row and one column back
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
//   always high; the user must make writes only while the block is idle, unchecked
// the first clamped frame_width+1 items of a frame give no result; after the last
//   data pixel, as many flush items drain the frame, the last with end_of_frame
// result path: input register then result register; result_valid rises once the
//   item that completes a pixel has passed through both registers
// throughput: one pixel per cycle while pixel_stall is low, served by one read
//   port on each line buffer and a thinning stage that overlaps commit and accept
// reset: counters, window and handshakes clear, config registers return to their
//   defaults; line buffers keep stale data until written
// a stalled result holds in the output register; the thinning stage keeps
//   taking items that give no result, and pixel_stall rises only when a
//   result-bearing item meets a full, stalled output register
`default_nettype none

module edge_non_maxima_suppression
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pixel_valid,
  output logic                           pixel_stall,
  input  wire pixel_t                    pixel,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output result_t                        result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  // common width to compare the width register against the line length
  localparam int EW = (WW > FRAME_W_BITS) ? WW : FRAME_W_BITS;

  // configuration registers
  logic [FRAME_W_BITS-1:0] frame_width;
  logic [FRAME_H_BITS-1:0] frame_height;
  logic [MAG_BITS-1:0]     min_magnitude;

  logic [EW-1:0]           width_ext;
  logic [WW-1:0]           width_eff;
  logic [ROW_BITS-1:0]     height_eff;

  logic                    accept;
  logic [CW-1:0]           col;
  pos_flags_t              flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RESET;
      frame_height  <= FRAME_HEIGHT_RESET;
      min_magnitude <= MIN_MAGNITUDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[FRAME_W_BITS-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[FRAME_H_BITS-1:0];
        CFG_MIN_MAGNITUDE: min_magnitude <= cfg_data[MAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to [3, MAX_WIDTH] and height to [3, MAX_HEIGHT]
  assign width_ext = EW'(frame_width);

  always_comb begin
    priority if (width_ext < EW'(3)) begin
      width_eff = WW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext[WW-1:0];
    end
  end

  always_comb begin
    priority if (frame_height < FRAME_H_BITS'(3)) begin
      height_eff = ROW_BITS'(3);
    end else if (frame_height > FRAME_H_BITS'(MAX_HEIGHT)) begin
      height_eff = ROW_BITS'(MAX_HEIGHT);
    end else begin
      height_eff = ROW_BITS'(frame_height);
    end
  end

  assign accept = pixel_valid && !pixel_stall;

  // raster position of the incoming item and what it will produce
  enms_position #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_position (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .col       (col),
    .flags     (flags)
  );

  // line buffers, window and the result register
  enms_thin #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_thin (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixel),
    .col          (col),
    .flags        (flags),
    .min_magnitude(min_magnitude),
    .stall        (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

/* design/enms_checker.sv */
`default_nettype none

`include "edge_non_maxima_suppression_macros.svh"

module enms_checker
  import enms_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    pixel_valid,
  input wire logic    pixel_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // input back-pressure only comes from a full, stalled output
  `ENMS_ASSERT_NOW(a_stall_cause, clk, rst, pixel_stall, result_valid && result_stall)

  // nothing is offered straight out of reset
  `ENMS_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !result_valid)

  // a stalled result is held
  `ENMS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
                    result_valid && $stable(result))

  // valid only drops after a transfer
  `ENMS_ASSERT_NOW(a_valid_drop, clk, rst, $fell(result_valid), !$past(result_stall))

endmodule

bind edge_non_maxima_suppression enms_checker u_checker (.*);

`default_nettype wire
